// ----- rtl/cpgs_pkg.sv -----
// Shared types and constants for the cubic pair gap statistics block.
// No dependencies.
`default_nettype none
package cpgs_pkg;
	localparam int MAX_SAMPLES = 4096;
	localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
	localparam int COEF_W      = 32;
	localparam int DIFF_W      = COEF_W + 1;
	localparam int POS_W       = 16;
	localparam int STEP_W      = 15;
	localparam int GAP_W       = 32;
	localparam int H_W         = GAP_W - 8;
	localparam int SUM_W       = GAP_W + CNT_W;
	localparam int SUM16_W     = H_W + CNT_W;
	localparam int SQ_W        = 2 * H_W + CNT_W;
	localparam int DVD_W       = SQ_W;
	localparam int DCNT_W      = $clog2(DVD_W + 1);
	localparam int ACC_W       = 48;
	localparam int XM_W        = POS_W + 1;
	localparam int PROD_W      = ACC_W + XM_W;
	localparam int T_W         = PROD_W + 1;
	localparam int X_W         = POS_W + 2;
	localparam int IDX_W       = 2;

	localparam logic [IDX_W-1:0] REG_SAMPLE_STEP  = 2'd0;
	localparam logic [IDX_W-1:0] REG_WINDOW_START = 2'd1;
	localparam logic [IDX_W-1:0] REG_WINDOW_END   = 2'd2;
	localparam logic [IDX_W-1:0] REG_HARD_WINDOW  = 2'd3;

	typedef struct packed {
		logic                     rng_short;
		logic signed [DIFF_W-1:0] d0;
		logic signed [DIFF_W-1:0] d1;
		logic signed [DIFF_W-1:0] d2;
		logic signed [DIFF_W-1:0] d3;
		logic signed [POS_W-1:0]  x_start;
		logic signed [POS_W-1:0]  x_end;
		logic [STEP_W-1:0]        step;
	} cpgs_job_t;
endpackage
`default_nettype wire

// ----- rtl/cubic_pair_gap_statistics.sv -----
// Each sample takes three multiply and add steps of one shared multiplier,
// then squaring and accumulation, for n samples up to 4096; three serial
// divisions, squaring of the mean and a final state then give the result.
// The back end works on one request at a time and waits while an earlier result
// is not popped; a request with a short range gives its result as it leaves the two-entry
// queue, which takes new requests while the back end works. Asynchronous
// active-low reset clears control state and sets the registers to defaults.
`default_nettype none
module cubic_pair_gap_statistics (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        push,
	output logic             full,
	input  wire logic signed [31:0] first_coeff_0,
	input  wire logic signed [31:0] first_coeff_1,
	input  wire logic signed [31:0] first_coeff_2,
	input  wire logic signed [31:0] first_coeff_3,
	input  wire logic signed [15:0] first_from_x,
	input  wire logic signed [15:0] first_to_x,
	input  wire logic signed [31:0] second_coeff_0,
	input  wire logic signed [31:0] second_coeff_1,
	input  wire logic signed [31:0] second_coeff_2,
	input  wire logic signed [31:0] second_coeff_3,
	input  wire logic signed [15:0] second_from_x,
	input  wire logic signed [15:0] second_to_x,
	output logic             empty,
	input  wire logic        pop,
	output logic             gap_valid,
	output logic [31:0]      mean_gap,
	output logic [31:0]      gap_variance
);
	import cpgs_pkg::*;

	cpgs_job_t fr_job;
	cpgs_job_t q_job;
	logic      q_empty;
	logic      q_rd;

	cpgs_front u_front (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.f_c0(first_coeff_0), .f_c1(first_coeff_1),
		.f_c2(first_coeff_2), .f_c3(first_coeff_3),
		.f_from(first_from_x), .f_to(first_to_x),
		.s_c0(second_coeff_0), .s_c1(second_coeff_1),
		.s_c2(second_coeff_2), .s_c3(second_coeff_3),
		.s_from(second_from_x), .s_to(second_to_x),
		.job(fr_job)
	);

	cpgs_queue u_queue (
		.clk, .arst_n, .wr(push), .wr_job(fr_job), .full,
		.rd(q_rd), .empty(q_empty), .rd_job(q_job)
	);

	cpgs_back u_back (
		.clk, .arst_n, .q_empty, .q_job, .q_rd, .empty, .pop,
		.gap_valid, .mean_gap, .gap_variance
	);
endmodule
`default_nettype wire

// ----- rtl/cpgs_front.sv -----
// Front end: configuration registers and classification of each request.
// Depends on cpgs_pkg.
`default_nettype none
module cpgs_front (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [cpgs_pkg::IDX_W-1:0]        cfg_index,
	input  wire logic [cpgs_pkg::POS_W-1:0]        cfg_data,
	input  wire logic signed [cpgs_pkg::COEF_W-1:0] f_c0,
	input  wire logic signed [cpgs_pkg::COEF_W-1:0] f_c1,
	input  wire logic signed [cpgs_pkg::COEF_W-1:0] f_c2,
	input  wire logic signed [cpgs_pkg::COEF_W-1:0] f_c3,
	input  wire logic signed [cpgs_pkg::POS_W-1:0]  f_from,
	input  wire logic signed [cpgs_pkg::POS_W-1:0]  f_to,
	input  wire logic signed [cpgs_pkg::COEF_W-1:0] s_c0,
	input  wire logic signed [cpgs_pkg::COEF_W-1:0] s_c1,
	input  wire logic signed [cpgs_pkg::COEF_W-1:0] s_c2,
	input  wire logic signed [cpgs_pkg::COEF_W-1:0] s_c3,
	input  wire logic signed [cpgs_pkg::POS_W-1:0]  s_from,
	input  wire logic signed [cpgs_pkg::POS_W-1:0]  s_to,
	output cpgs_pkg::cpgs_job_t                     job
);
	import cpgs_pkg::*;

	logic [STEP_W-1:0]       step_q;
	logic signed [POS_W-1:0] wstart_q;
	logic signed [POS_W-1:0] wend_q;
	logic                    hard_q;
	logic signed [POS_W-1:0] st;
	logic signed [POS_W-1:0] en;
	logic [STEP_W-1:0]       stp;
	logic signed [X_W-1:0]   span;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= STEP_W'(64);
			wstart_q <= '0;
			wend_q   <= POS_W'(3200);
			hard_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SAMPLE_STEP:  step_q   <= cfg_data[STEP_W-1:0];
				REG_WINDOW_START: wstart_q <= cfg_data;
				REG_WINDOW_END:   wend_q   <= cfg_data;
				REG_HARD_WINDOW:  hard_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		st = wstart_q;
		en = wend_q;
		if (!hard_q) begin
			if (f_from > st) st = f_from;
			if (s_from > st) st = s_from;
			if (f_to < en) en = f_to;
			if (s_to < en) en = s_to;
		end
		stp  = (step_q == '0) ? STEP_W'(1) : step_q;
		span = X_W'(en) - X_W'(st);
		job.rng_short = span < $signed({3'b000, stp});
		job.d0 = DIFF_W'(f_c0) - DIFF_W'(s_c0);
		job.d1 = DIFF_W'(f_c1) - DIFF_W'(s_c1);
		job.d2 = DIFF_W'(f_c2) - DIFF_W'(s_c2);
		job.d3 = DIFF_W'(f_c3) - DIFF_W'(s_c3);
		job.x_start = st;
		job.x_end   = en;
		job.step    = stp;
	end
endmodule
`default_nettype wire

// ----- rtl/cpgs_queue.sv -----
// Two-entry queue of classified requests between front and back end.
// Depends on cpgs_pkg.
`default_nettype none
module cpgs_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                wr,
	input  cpgs_pkg::cpgs_job_t      wr_job,
	output logic                     full,
	input  wire logic                rd,
	output logic                     empty,
	output cpgs_pkg::cpgs_job_t      rd_job
);
	import cpgs_pkg::*;

	cpgs_job_t  mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full   = cnt_q == 2'd2;
	assign empty  = cnt_q == 2'd0;
	assign rd_job = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr && !full) mem_q[wp_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr && !full) wp_q <= !wp_q;
			if (rd && !empty) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'((wr && !full) ? 1 : 0) - 2'((rd && !empty) ? 1 : 0);
		end
	end
endmodule
`default_nettype wire

// ----- rtl/cpgs_back.sv -----
// Back end: sampling sequencer with shared Horner multiplier, serial divider
// and the result register. Depends on cpgs_pkg.
`default_nettype none
module cpgs_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                q_empty,
	input  cpgs_pkg::cpgs_job_t      q_job,
	output logic                     q_rd,
	output logic                     empty,
	input  wire logic                pop,
	output logic                     gap_valid,
	output logic [31:0]              mean_gap,
	output logic [31:0]              gap_variance
);
	import cpgs_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_MUL  = 8'b0000_0010,
		ST_ADD  = 8'b0000_0100,
		ST_SQ   = 8'b0000_1000,
		ST_ACC  = 8'b0001_0000,
		ST_DIV  = 8'b0010_0000,
		ST_MSQ  = 8'b0100_0000,
		ST_FIN  = 8'b1000_0000
	} state_t;

	typedef enum logic [1:0] {
		DV_SUM = 2'd0,
		DV_SQ  = 2'd1,
		DV_S16 = 2'd2
	} dsel_t;

	state_t                   st_q;
	dsel_t                    dsel_q;
	cpgs_job_t                job_q;
	logic [1:0]               k_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [X_W-1:0]    x_q;
	logic [CNT_W-1:0]         n_q;
	logic [GAP_W-1:0]         g_q;
	logic [2*H_W-1:0]         hsq_q;
	logic [SUM_W-1:0]         sum_q;
	logic [SUM16_W-1:0]       s16_q;
	logic [SQ_W-1:0]          ssq_q;
	logic [DVD_W-1:0]         dvd_q;
	logic [CNT_W-1:0]         rem_q;
	logic [DCNT_W-1:0]        dcnt_q;
	logic [GAP_W-1:0]         qsum_q;
	logic [DVD_W-1:0]         qsq_q;
	logic [H_W-1:0]           q16_q;
	logic [2*H_W-1:0]         msq_q;
	logic                     ov_q;
	logic                     gv_q;
	logic [31:0]              mg_q;
	logic [31:0]              var_q;

	logic signed [T_W-1:0]    addend;
	logic signed [T_W-1:0]    t;
	logic signed [T_W-1:0]    tc;
	logic [T_W-1:0]           mag;
	logic [GAP_W-1:0]         g;
	logic [CNT_W:0]           shf;
	logic                     qbit;
	logic [CNT_W-1:0]         rem_n;
	logic [DVD_W-1:0]         quo;
	logic [DVD_W-1:0]         vdiff;

	localparam logic signed [T_W-1:0] LIM = T_W'(1) <<< 46;

	assign empty        = !ov_q;
	assign gap_valid    = gv_q;
	assign mean_gap     = mg_q;
	assign gap_variance = var_q;
	assign q_rd         = (st_q == ST_IDLE) && !q_empty && !ov_q;

	always_comb begin
		unique case (k_q)
			2'd0:    addend = T_W'(job_q.d2);
			2'd1:    addend = T_W'(job_q.d1);
			default: addend = T_W'(job_q.d0);
		endcase
		t  = T_W'(prod_q >>> 6) + addend;
		tc = t;
		if (t > LIM) tc = LIM;
		if (t < -LIM) tc = -LIM;
		mag = t[T_W-1] ? T_W'(-t) : T_W'(t);
		g   = (|mag[T_W-1:GAP_W]) ? '1 : mag[GAP_W-1:0];
		shf = {rem_q, dvd_q[DVD_W-1]};
		qbit = shf >= {1'b0, n_q};
		rem_n = qbit ? CNT_W'(shf - {1'b0, n_q}) : shf[CNT_W-1:0];
		quo = {dvd_q[DVD_W-2:0], qbit};
		vdiff = qsq_q - DVD_W'(msq_q);
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				job_q <= q_job;
				acc_q <= ACC_W'(q_job.d3);
				x_q   <= X_W'(q_job.x_start);
				k_q   <= 2'd0;
				sum_q <= '0;
				s16_q <= '0;
				ssq_q <= '0;
			end
			ST_MUL: prod_q <= acc_q * $signed(x_q[XM_W-1:0]);
			ST_ADD: begin
				if (k_q == 2'd2) begin
					g_q <= g;
				end else begin
					acc_q <= ACC_W'(tc);
					k_q   <= k_q + 2'd1;
				end
			end
			ST_SQ: begin
				hsq_q <= g_q[GAP_W-1:8] * g_q[GAP_W-1:8];
				sum_q <= sum_q + SUM_W'(g_q);
				s16_q <= s16_q + SUM16_W'(g_q[GAP_W-1:8]);
				x_q   <= x_q + X_W'(job_q.step);
			end
			ST_ACC: begin
				ssq_q  <= ssq_q + SQ_W'(hsq_q);
				acc_q  <= ACC_W'(job_q.d3);
				k_q    <= 2'd0;
				dvd_q  <= DVD_W'(sum_q);
				rem_q  <= '0;
				dcnt_q <= '0;
			end
			ST_DIV: begin
				if (dcnt_q == DCNT_W'(DVD_W - 1)) begin
					rem_q  <= '0;
					dcnt_q <= '0;
					unique case (dsel_q)
						DV_SUM: begin
							qsum_q <= quo[GAP_W-1:0];
							dvd_q  <= ssq_q;
						end
						DV_SQ: begin
							qsq_q <= quo;
							dvd_q <= DVD_W'(s16_q);
						end
						default: begin
							q16_q <= quo[H_W-1:0];
							dvd_q <= quo;
						end
					endcase
				end else begin
					dvd_q  <= quo;
					rem_q  <= rem_n;
					dcnt_q <= dcnt_q + DCNT_W'(1);
				end
			end
			ST_MSQ: msq_q <= q16_q * q16_q;
			ST_FIN: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			dsel_q <= DV_SUM;
			n_q    <= '0;
			ov_q   <= 1'b0;
			gv_q   <= 1'b0;
			mg_q   <= '0;
			var_q  <= '0;
		end else begin
			if (pop && ov_q) ov_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					n_q    <= '0;
					dsel_q <= DV_SUM;
					if (q_rd) begin
						if (q_job.rng_short) begin
							ov_q  <= 1'b1;
							gv_q  <= 1'b0;
							mg_q  <= '0;
							var_q <= '0;
						end else begin
							st_q <= ST_MUL;
						end
					end
				end
				ST_MUL: st_q <= ST_ADD;
				ST_ADD: st_q <= (k_q == 2'd2) ? ST_SQ : ST_MUL;
				ST_SQ: begin
					n_q  <= n_q + CNT_W'(1);
					st_q <= ST_ACC;
				end
				ST_ACC: begin
					if (x_q < X_W'(job_q.x_end) && n_q < CNT_W'(MAX_SAMPLES)) st_q <= ST_MUL;
					else st_q <= ST_DIV;
				end
				ST_DIV: begin
					if (dcnt_q == DCNT_W'(DVD_W - 1)) begin
						unique case (dsel_q)
							DV_SUM:  dsel_q <= DV_SQ;
							DV_SQ:   dsel_q <= DV_S16;
							default: st_q   <= ST_MSQ;
						endcase
					end
				end
				ST_MSQ: st_q <= ST_FIN;
				ST_FIN: begin
					if (!ov_q) begin
						ov_q  <= 1'b1;
						gv_q  <= 1'b1;
						mg_q  <= qsum_q;
						var_q <= (qsq_q > DVD_W'(msq_q)) ?
							((|vdiff[DVD_W-1:48]) ? '1 : vdiff[47:16]) : '0;
						st_q  <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- tb/cubic_pair_gap_statistics_checker.sv -----
// Checker for the cubic pair gap statistics block: watches the configuration
// port and both queue channels, predicts each result and compares it.
// Depends on cpgs_pkg for the register indexes and the sample limit.
module cubic_pair_gap_statistics_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        push,
	input  wire logic        full,
	input  wire logic signed [31:0] first_coeff_0,
	input  wire logic signed [31:0] first_coeff_1,
	input  wire logic signed [31:0] first_coeff_2,
	input  wire logic signed [31:0] first_coeff_3,
	input  wire logic signed [15:0] first_from_x,
	input  wire logic signed [15:0] first_to_x,
	input  wire logic signed [31:0] second_coeff_0,
	input  wire logic signed [31:0] second_coeff_1,
	input  wire logic signed [31:0] second_coeff_2,
	input  wire logic signed [31:0] second_coeff_3,
	input  wire logic signed [15:0] second_from_x,
	input  wire logic signed [15:0] second_to_x,
	input  wire logic        empty,
	input  wire logic        pop,
	input  wire logic        gap_valid,
	input  wire logic [31:0] mean_gap,
	input  wire logic [31:0] gap_variance,
	output int               failures,
	output int               pending,
	output int               checked,
	output int               valid_seen
);
	import cpgs_pkg::*;

	typedef struct packed {
		logic        valid;
		logic [31:0] mean;
		logic [31:0] variance;
	} gap_stats_t;

	logic [14:0]        step_reg;
	logic signed [15:0] win_start_reg;
	logic signed [15:0] win_end_reg;
	logic               hard_reg;
	gap_stats_t         expected_stats[$];

	function automatic logic [31:0] gap_at(longint d[4], longint x);
		longint acc;
		longint lim;
		acc = d[3];
		lim = longint'(1) <<< 46;
		acc = ((acc * x) >>> 6) + d[2];
		acc = ((acc * x) >>> 6) + d[1];
		if (acc > lim)
			acc = lim;
		if (acc < -lim)
			acc = -lim;
		acc = ((acc * x) >>> 6) + d[0];
		if (acc < 0)
			acc = -acc;
		return (acc > 64'sh0FFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
	endfunction

	function automatic gap_stats_t predict_gap_stats();
		gap_stats_t r;
		longint d[4];
		longint lo, hi, st, x;
		longint unsigned n, sum, sum16, sumsq, h, m2, mean16, sq, var64;
		logic [31:0] g;
		d[0] = longint'(first_coeff_0) - longint'(second_coeff_0);
		d[1] = longint'(first_coeff_1) - longint'(second_coeff_1);
		d[2] = longint'(first_coeff_2) - longint'(second_coeff_2);
		d[3] = longint'(first_coeff_3) - longint'(second_coeff_3);
		lo = longint'(win_start_reg);
		hi = longint'(win_end_reg);
		if (!hard_reg) begin
			if (first_from_x > lo) lo = longint'(first_from_x);
			if (second_from_x > lo) lo = longint'(second_from_x);
			if (first_to_x < hi) hi = longint'(first_to_x);
			if (second_to_x < hi) hi = longint'(second_to_x);
		end
		st = (step_reg == 0) ? 1 : longint'(step_reg);
		r = '0;
		if (hi - lo < st)
			return r;
		n = 0; sum = 0; sum16 = 0; sumsq = 0;
		for (x = lo; x < hi && n < MAX_SAMPLES; x += st) begin
			g = gap_at(d, x);
			h = 64'(g >> 8);
			sum += 64'(g);
			sum16 += h;
			sumsq += h * h;
			n++;
		end
		m2 = sumsq / n;
		mean16 = sum16 / n;
		sq = mean16 * mean16;
		var64 = (m2 > sq) ? (m2 - sq) >> 16 : 0;
		r.valid = 1'b1;
		r.mean = 32'(sum / n);
		r.variance = (var64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : var64[31:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
		$display("mismatch at result %0d: %s expected %h, got %h", checked, what, want, got);
		failures++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_reg      <= 15'd64;
			win_start_reg <= 16'sd0;
			win_end_reg   <= 16'sd3200;
			hard_reg      <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SAMPLE_STEP:  step_reg <= cfg_data[14:0];
				REG_WINDOW_START: win_start_reg <= cfg_data;
				REG_WINDOW_END:   win_end_reg <= cfg_data;
				REG_HARD_WINDOW:  hard_reg <= cfg_data[0];
				default: ;
			endcase
		end
	end

	initial begin
		failures = 0;
		checked = 0;
		valid_seen = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		gap_stats_t e;
		if (arst_n && push && !full)
			expected_stats = {expected_stats, predict_gap_stats()};
		if (arst_n && pop && !empty) begin
			if (expected_stats.size() == 0) begin
				report_mismatch("unrequested result, valid", 32'd0, {31'd0, gap_valid});
			end else begin
				e = expected_stats.pop_front();
				if (gap_valid !== e.valid)
					report_mismatch("gap_valid", {31'd0, e.valid}, {31'd0, gap_valid});
				if (mean_gap !== e.mean)
					report_mismatch("mean_gap", e.mean, mean_gap);
				if (gap_variance !== e.variance)
					report_mismatch("gap_variance", e.variance, gap_variance);
				if (e.valid)
					valid_seen++;
			end
			checked++;
		end
		pending = expected_stats.size();
	end
endmodule

// ----- tb/cubic_pair_gap_statistics_tb.sv -----
// Testbench top for the cubic pair gap statistics block: drives requests and
// register writes, stalls the result side and gives the verdict.
// Depends on cpgs_pkg and on cubic_pair_gap_statistics_checker.
module cubic_pair_gap_statistics_tb;
	import cpgs_pkg::*;

	localparam int IDLE_LIMIT = 200000;

	typedef struct {
		logic signed [31:0] fc[4];
		logic signed [15:0] ff, ft;
		logic signed [31:0] sc[4];
		logic signed [15:0] sf, st;
	} curve_pair_t;

	logic clk = 0, arst_n = 0;
	logic cfg_we = 0;
	logic [1:0] cfg_index = REG_SAMPLE_STEP;
	logic [15:0] cfg_data = 0;
	logic push = 0, pop = 0;
	logic full, empty, gap_valid;
	logic [31:0] mean_gap, gap_variance;
	logic signed [31:0] first_coeff_0 = 0, first_coeff_1 = 0, first_coeff_2 = 0;
	logic signed [31:0] first_coeff_3 = 0, second_coeff_0 = 0, second_coeff_1 = 0;
	logic signed [31:0] second_coeff_2 = 0, second_coeff_3 = 0;
	logic signed [15:0] first_from_x = 0, first_to_x = 0, second_from_x = 0, second_to_x = 0;
	int failures, pending, checked, valid_seen;
	int idle_cycles = 0, sent = 0;
	int cur_ws = 0, cur_we = 3200;
	int hold_cnt = 0;
	bit hold_go = 0;
	int pop_mode = 0, mode_left = 0;

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	cubic_pair_gap_statistics uut (.*);

	cubic_pair_gap_statistics_checker chk (.*);

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (mode_left == 0) begin
			pop_mode = $urandom_range(0, 3);
			mode_left = $urandom_range(20, 150);
		end else begin
			mode_left--;
		end
		if (hold_go) begin
			hold_go = 0;
			hold_cnt = 600;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			pop <= 1'b0;
		end else begin
			case (pop_mode)
				0: pop <= 1'b1;
				1: pop <= ($urandom_range(0, 1) == 1);
				2: pop <= ($urandom_range(0, 4) == 0);
				default: pop <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(int step, int ws, int we, int hard);
		push <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (30) @(posedge clk);
		write_reg(REG_SAMPLE_STEP, 16'(step));
		write_reg(REG_WINDOW_START, 16'(ws));
		write_reg(REG_WINDOW_END, 16'(we));
		write_reg(REG_HARD_WINDOW, 16'(hard));
		cur_ws = ws;
		cur_we = we;
	endtask

	// Offers one request from a rising edge; returns once taken and gap is over.
	task automatic send_pair(curve_pair_t p, int gap);
		first_coeff_0 <= p.fc[0]; first_coeff_1 <= p.fc[1];
		first_coeff_2 <= p.fc[2]; first_coeff_3 <= p.fc[3];
		second_coeff_0 <= p.sc[0]; second_coeff_1 <= p.sc[1];
		second_coeff_2 <= p.sc[2]; second_coeff_3 <= p.sc[3];
		first_from_x <= p.ff; first_to_x <= p.ft;
		second_from_x <= p.sf; second_to_x <= p.st;
		push <= 1'b1;
		do @(posedge clk); while (full);
		sent++;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic signed [31:0] rand_coeff();
		case ($urandom_range(0, 4))
			0: return $signed($urandom_range(0, 2097151)) - 1048576;
			1: return 32'sd0;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [15:0] near(int v);
		int r;
		r = v + $signed($urandom_range(0, 200)) - 100;
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return 16'(r);
	endfunction

	function automatic curve_pair_t random_pair();
		curve_pair_t p;
		for (int i = 0; i < 4; i++) begin
			p.fc[i] = rand_coeff();
			p.sc[i] = ($urandom_range(0, 5) == 0) ? p.fc[i] : rand_coeff();
		end
		if ($urandom_range(0, 4) != 0) begin
			p.ff = near(cur_ws); p.ft = near(cur_we);
			p.sf = near(cur_ws); p.st = near(cur_we);
		end else begin
			p.ff = 16'($urandom); p.ft = 16'($urandom);
			p.sf = 16'($urandom); p.st = 16'($urandom);
		end
		return p;
	endfunction

	function automatic curve_pair_t flat_pair(logic signed [31:0] a, logic signed [31:0] b,
			int lo, int hi);
		curve_pair_t p;
		for (int i = 0; i < 4; i++) begin
			p.fc[i] = a;
			p.sc[i] = b;
		end
		p.ff = 16'(lo); p.ft = 16'(hi); p.sf = 16'(lo); p.st = 16'(hi);
		return p;
	endfunction

	task automatic random_burst(int count);
		int left, gap;
		left = 0;
		for (int i = 0; i < count; i++) begin
			if (left == 0) begin
				left = $urandom_range(1, 12);
				gap = $urandom_range(1, 25);
			end
			left--;
			send_pair(random_pair(), (left == 0) ? gap : 0);
		end
	endtask

	initial begin
		curve_pair_t p;
		int ws, we, span, step;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pair(flat_pair(0, 0, -32768, 32767), 0);
		send_pair(flat_pair(32'sh7FFF_FFFF, 32'sh8000_0000, -32768, 32767), 0);
		send_pair(flat_pair(32'sh8000_0000, 32'sh7FFF_FFFF, 0, 3200), 1);
		send_pair(flat_pair(32'sh0100_0000, 0, 0, 64), 0);
		send_pair(flat_pair(32'sh0100_0000, 0, 0, 63), 0);
		send_pair(flat_pair(32'sh0100_0000, 0, 3000, 100), 2);
		send_pair(flat_pair(32'sh0001_0000, 32'sh0002_0000, 4000, 5000), 0);
		send_pair(flat_pair(32'shFFFF_FFFF, 0, -5000, -10), 0);
		p = flat_pair(32'sh0000_1000, 32'sh0000_0100, 500, 2000);
		p.ft = 16'sd1000;
		p.sf = 16'sd700;
		send_pair(p, 3);
		for (int i = 0; i < 6; i++)
			send_pair(random_pair(), i % 2);

		// The sample limit, a step of one and the hard window at the extremes.
		set_config(1, -32768, 32767, 1);
		send_pair(flat_pair(32'sh0000_0400, 32'sh0000_0001, 0, 0), 0);
		send_pair(random_pair(), 0);
		set_config(32767, -32768, 32767, 0);
		random_burst(40);
		set_config(0, 100, 120, 0);
		random_burst(40);
		set_config(200, 32767, -32768, 1);
		random_burst(10);

		for (int ph = 0; ph < 7; ph++) begin
			ws = $signed($urandom_range(0, 65535)) - 32768;
			we = $signed($urandom_range(0, 65535)) - 32768;
			if ($urandom_range(0, 3) != 0 && we < ws) begin
				span = ws; ws = we; we = span;
			end
			span = we - ws;
			step = (span > 0) ? span / $urandom_range(1, 24) : $urandom_range(1, 32767);
			if (step < 1) step = 1;
			if (step > 32767) step = 32767;
			set_config(step, ws, we, $urandom_range(0, 1));
			if (ph == 2) begin
				hold_go = 1;
				for (int i = 0; i < 30; i++)
					send_pair(random_pair(), 0);
			end
			random_burst(110);
		end

		push <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (400) @(posedge clk);
		$display("Sent %0d curve pairs over twelve register settings; %0d results checked,",
			sent, checked);
		$display("%0d with a usable range, %0d mismatches.", valid_seen, failures);
		if (failures == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
